// ----- sv/dq_pkg.sv -----
`timescale 1ns / 1ps

package dq_pkg;

  localparam int WordWidth = 32;
  localparam int CmdWidth  = 3;

  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_FRONT      = 3'd4,
    CMD_BACK       = 3'd5,
    CMD_SIZE       = 3'd6,
    CMD_EMPTY      = 3'd7
  } cmd_t;

  localparam logic signed [WordWidth-1:0] EmptyAnswer = -32'sd1;

  typedef struct packed {
    logic [CmdWidth-1:0]         command;
    logic signed [WordWidth-1:0] push_value;
  } item_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] answer;
    logic                        rejected;
  } result_t;

  // Strobes of one memory access; the addresses travel beside them.
  typedef struct packed {
    logic wen;
    logic ren;
  } mem_ctl_t;

  // What the controller tells the output stage about the result of this cycle.
  typedef struct packed {
    logic    valid;
    logic    use_mem;
    result_t imm;
  } res_ctl_t;

endpackage

// ----- sv/dq_store.sv -----
`timescale 1ns / 1ps

module dq_store #(
  parameter int Depth = 1024,
  parameter int AddrWidth = 10
) (
  input  logic                              clk,
  input  dq_pkg::mem_ctl_t                  ctl,
  input  logic [AddrWidth-1:0]              waddr,
  input  logic signed [dq_pkg::WordWidth-1:0] wdata,
  input  logic [AddrWidth-1:0]              raddr,
  output logic signed [dq_pkg::WordWidth-1:0] rdata
);
  import dq_pkg::*;

  logic signed [WordWidth-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (ctl.wen) begin
      mem[waddr] <= wdata;
    end
    if (ctl.ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/dq_ctrl.sv -----
`timescale 1ns / 1ps

module dq_ctrl #(
  parameter int Capacity = 1024,
  parameter int PtrWidth = 10,
  parameter int CntWidth = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  dq_pkg::item_t         item,
  output dq_pkg::mem_ctl_t      mem_ctl,
  output logic [PtrWidth-1:0]   waddr,
  output logic [PtrWidth-1:0]   raddr,
  output dq_pkg::res_ctl_t      res,
  output logic [CntWidth-1:0]   count
);
  import dq_pkg::*;

  localparam logic [CntWidth:0] CapWide = (CntWidth+1)'(Capacity);

  logic [PtrWidth-1:0] head;
  logic [PtrWidth-1:0] head_next;
  logic [CntWidth-1:0] count_next;
  res_ctl_t            res_next;
  logic                empty;
  logic                full;

  // Circular add: base is below the capacity and offset at most the capacity,
  // so a single conditional subtract brings the sum back in range.
  function automatic logic [PtrWidth-1:0] wrap_add(logic [PtrWidth-1:0] base,
                                                   logic [CntWidth-1:0] offset);
    logic [CntWidth:0] sum;
    sum = (CntWidth+1)'(base) + (CntWidth+1)'(offset);
    if (sum >= CapWide) begin
      sum = sum - CapWide;
    end
    return sum[PtrWidth-1:0];
  endfunction

  assign empty = (count == '0);
  assign full  = (count == CntWidth'(Capacity));

  always_comb begin
    head_next    = head;
    count_next   = count;
    mem_ctl      = '0;
    waddr        = wrap_add(head, count);
    raddr        = head;
    res_next     = '0;
    if (accept) begin
      unique case (cmd_t'(item.command))
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (full) begin
            res_next.valid        = 1'b1;
            res_next.imm.rejected = 1'b1;
          end else begin
            mem_ctl.wen = 1'b1;
            count_next  = count + 1'b1;
            if (cmd_t'(item.command) == CMD_PUSH_FRONT) begin
              head_next = (head == '0) ? PtrWidth'(Capacity - 1) : head - 1'b1;
              waddr     = head_next;
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK, CMD_FRONT, CMD_BACK: begin
          res_next.valid = 1'b1;
          if (empty) begin
            res_next.imm.answer = EmptyAnswer;
          end else begin
            mem_ctl.ren      = 1'b1;
            res_next.use_mem = 1'b1;
            if (cmd_t'(item.command) == CMD_POP_BACK ||
                cmd_t'(item.command) == CMD_BACK) begin
              raddr = wrap_add(head, count - 1'b1);
            end
            if (cmd_t'(item.command) == CMD_POP_FRONT) begin
              head_next  = wrap_add(head, CntWidth'(1));
              count_next = count - 1'b1;
            end else if (cmd_t'(item.command) == CMD_POP_BACK) begin
              count_next = count - 1'b1;
            end
          end
        end
        CMD_SIZE: begin
          res_next.valid      = 1'b1;
          res_next.imm.answer = WordWidth'(count);
        end
        CMD_EMPTY: begin
          res_next.valid      = 1'b1;
          res_next.imm.answer = WordWidth'(empty);
        end
        default: begin
          res_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      res.valid <= res_next.valid;
    end
    res.use_mem <= res_next.use_mem;
    res.imm     <= res_next.imm;
  end

endmodule

// ----- sv/double_ended_queue.sv -----
`timescale 1ns / 1ps

// Channel   Ports                  Transfer
// command   start, busy, item      start high and busy low at a rising edge
// result    done, result           done high for one cycle, taken at its end
//
// The pointers update at the accepting edge of a command, and
// the single store access (write for a push, registered read for a pop or peek)
// happens at that same edge. The result shows in the cycle after acceptance, the
// read data coming straight from the store's output register.
// Reset is synchronous and clears the head pointer, the count and the strobe;
// busy is high only while reset is held. The receiver cannot stall results.

module double_ended_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dq_pkg::item_t   item,
  output logic            done,
  output dq_pkg::result_t result
);
  import dq_pkg::*;

  localparam int PtrWidth = $clog2(CAPACITY);
  localparam int CntWidth = $clog2(CAPACITY + 1);

  logic                        accept;
  mem_ctl_t                    mem_ctl;
  logic [PtrWidth-1:0]         waddr;
  logic [PtrWidth-1:0]         raddr;
  logic signed [WordWidth-1:0] rdata;
  res_ctl_t                    res;
  logic [CntWidth-1:0]         count;

  assign busy   = rst;
  assign accept = start && !busy;

  dq_ctrl #(
    .Capacity(CAPACITY),
    .PtrWidth(PtrWidth),
    .CntWidth(CntWidth)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .mem_ctl(mem_ctl),
    .waddr  (waddr),
    .raddr  (raddr),
    .res    (res),
    .count  (count)
  );

  dq_store #(
    .Depth    (CAPACITY),
    .AddrWidth(PtrWidth)
  ) u_store (
    .clk  (clk),
    .ctl  (mem_ctl),
    .waddr(waddr),
    .wdata(item.push_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign done            = res.valid;
  assign result.answer   = res.use_mem ? rdata : res.imm.answer;
  assign result.rejected = res.imm.rejected;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntWidth'(CAPACITY))
    else $error("item count exceeds capacity");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.wen && mem_ctl.ren))
    else $error("store written and read for the same command");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.rejected) |-> (result.answer == '0 && !res.use_mem))
    else $error("rejected push carries a nonzero answer");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && mem_ctl.wen) |=> (count == $past(count) + 1'b1))
    else $error("accepted push did not grow the count");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result strobe without an accepted command");

endmodule
